// ===== design/u8u16_pkg.sv =====
// Shared types, constants and helper functions of the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

  // Width of the byte position counters; positions wrap at 2**INDEX_BITS.
  localparam int unsigned INDEX_BITS = 16;
  localparam int unsigned UNIT_W     = 16;

  // Depth of the queue between front end and back end.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [UNIT_W-1:0] QMARK     = 16'h003F;
  localparam logic [UNIT_W-1:0] MAX_RESET = 16'hFFFF;

  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;

  typedef logic [INDEX_BITS-1:0] pos_t;

  typedef enum logic [1:0] {
    BC_ASCII,
    BC_LEAD2,
    BC_LEAD3,
    BC_BAD
  } byte_class_e;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_INCOMPLETE = 2'd1,
    ST_NO_SPACE   = 2'd2
  } status_e;

  // One queue entry per accepted byte: up to three candidate units plus
  // the end-of-string information.
  typedef struct packed {
    logic [2:0][UNIT_W-1:0] units;
    logic [1:0]             n_units;
    logic                   last_byte;
    logic                   incomplete;
    logic [UNIT_W-1:0]      stop_idx;
  } dec_entry_t;

  function automatic byte_class_e classify(input logic [7:0] b);
    byte_class_e c;
    if (b[7] == 1'b0) begin
      c = BC_ASCII;
    end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
      c = BC_LEAD2;
    end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
      c = BC_LEAD3;
    end else begin
      c = BC_BAD;
    end
    return c;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & MASK_CONT) == PAT_CONT;
  endfunction

endpackage

`default_nettype wire

// ===== design/u8u16_if.sv =====
// Valid/ready channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps
`default_nettype none

interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        final_item;
  logic [1:0]  status;
  logic [15:0] stop_index;
  logic [15:0] units_written;

  modport source (output valid, output code_unit, output unit_valid, output final_item,
                  output status, output stop_index, output units_written, input ready);
  modport sink   (input valid, input code_unit, input unit_valid, input final_item,
                  input status, input stop_index, input units_written, output ready);
endinterface

`default_nettype wire

// ===== design/u8u16_front.sv =====
// Front end: accepts bytes, tracks open sequences, emits candidate units per byte.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  u8u16_byte_if.sink         in_i,
  input  wire logic          full_i,
  output logic               push_o,
  output u8u16_pkg::dec_entry_t entry_o
);

  typedef struct packed {
    logic [1:0][u8u16_pkg::UNIT_W-1:0] units;
    logic [1:0]                        n;
    logic                              inc;
    u8u16_pkg::pos_t                   inc_pos;
    logic [1:0]                        next_cnt;
    logic [7:0]                        next_lead;
    logic [7:0]                        next_first;
    u8u16_pkg::pos_t                   next_lpos;
  } feed_res_t;

  // Byte seen with no sequence open.
  function automatic feed_res_t feed_new(input logic [7:0] b, input u8u16_pkg::pos_t pos,
                                         input logic last);
    feed_res_t r;
    r = '0;
    case (u8u16_pkg::classify(b))
      u8u16_pkg::BC_ASCII: begin
        r.units[0] = {8'h00, b};
        r.n        = 2'd1;
      end
      u8u16_pkg::BC_LEAD2, u8u16_pkg::BC_LEAD3: begin
        if (last) begin
          r.inc     = 1'b1;
          r.inc_pos = pos;
        end else begin
          r.next_cnt  = 2'd1;
          r.next_lead = b;
          r.next_lpos = pos;
        end
      end
      default: begin
        r.units[0] = u8u16_pkg::QMARK;
        r.n        = 2'd1;
      end
    endcase
    return r;
  endfunction

  // Byte seen with nothing held, or with just the lead held.
  function automatic feed_res_t feed_open(input logic held, input logic [7:0] lead,
                                          input u8u16_pkg::pos_t lpos, input logic [7:0] b,
                                          input u8u16_pkg::pos_t pos, input logic last);
    feed_res_t r;
    feed_res_t t;
    r = '0;
    t = '0;
    if (!held) begin
      r = feed_new(b, pos, last);
    end else if (u8u16_pkg::classify(lead) == u8u16_pkg::BC_LEAD2) begin
      if (u8u16_pkg::is_cont(b)) begin
        r.units[0] = {5'd0, lead[4:0], b[5:0]};
        r.n        = 2'd1;
      end else begin
        // lead dropped, byte decoded again as a new byte
        t          = feed_new(b, pos, last);
        r          = t;
        r.units[0] = u8u16_pkg::QMARK;
        r.units[1] = t.units[0];
        r.n        = t.n + 2'd1;
      end
    end else begin
      if (last) begin
        r.inc     = 1'b1;
        r.inc_pos = lpos;
      end else begin
        r.next_cnt   = 2'd2;
        r.next_lead  = lead;
        r.next_first = b;
        r.next_lpos  = lpos;
      end
    end
    return r;
  endfunction

  logic [1:0]      cnt_q, cnt_d;
  logic [7:0]      lead_q, lead_d;
  logic [7:0]      first_q, first_d;
  u8u16_pkg::pos_t lpos_q, lpos_d;
  u8u16_pkg::pos_t bpos_q, bpos_d;
  logic            accept;
  feed_res_t       t1, t2, nxt;
  u8u16_pkg::dec_entry_t e;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign push_o     = accept;
  assign entry_o    = e;

  always_comb begin
    t1 = '0;
    t2 = '0;
    e  = '0;
    if (cnt_q == 2'd2) begin
      if (u8u16_pkg::is_cont(first_q) && u8u16_pkg::is_cont(in_i.in_byte)) begin
        e.units[0] = {lead_q[3:0], first_q[5:0], in_i.in_byte[5:0]};
        e.n_units  = 2'd1;
      end else begin
        // lead dropped: the held first follower, then this byte, act as new bytes
        t1 = feed_new(first_q, u8u16_pkg::pos_t'(lpos_q + 1'b1), 1'b0);
        t2 = feed_open(t1.next_cnt[0], t1.next_lead, t1.next_lpos, in_i.in_byte, bpos_q,
                       in_i.end_of_string);
        e.units[0] = u8u16_pkg::QMARK;
        if (t1.n != 2'd0) begin
          e.units[1] = t1.units[0];
          e.units[2] = t2.units[0];
          e.n_units  = t2.n + 2'd2;
        end else begin
          e.units[1] = t2.units[0];
          e.units[2] = t2.units[1];
          e.n_units  = t2.n + 2'd1;
        end
      end
    end else begin
      t2 = feed_open(cnt_q[0], lead_q, lpos_q, in_i.in_byte, bpos_q, in_i.end_of_string);
      e.units[0] = t2.units[0];
      e.units[1] = t2.units[1];
      e.n_units  = t2.n;
    end
    nxt          = t2;
    e.last_byte  = in_i.end_of_string;
    e.incomplete = t2.inc;
    e.stop_idx   = u8u16_pkg::UNIT_W'(t2.inc_pos);
  end

  always_comb begin
    cnt_d   = cnt_q;
    lead_d  = lead_q;
    first_d = first_q;
    lpos_d  = lpos_q;
    bpos_d  = bpos_q;
    if (accept) begin
      if (in_i.end_of_string) begin
        cnt_d   = 2'd0;
        lead_d  = 8'h00;
        first_d = 8'h00;
        lpos_d  = '0;
        bpos_d  = '0;
      end else begin
        cnt_d   = nxt.next_cnt;
        lead_d  = nxt.next_lead;
        first_d = nxt.next_first;
        lpos_d  = nxt.next_lpos;
        bpos_d  = u8u16_pkg::pos_t'(bpos_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 2'd0;
      lead_q  <= 8'h00;
      first_q <= 8'h00;
      lpos_q  <= '0;
      bpos_q  <= '0;
    end else begin
      cnt_q   <= cnt_d;
      lead_q  <= lead_d;
      first_q <= first_d;
      lpos_q  <= lpos_d;
      bpos_q  <= bpos_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/u8u16_queue.sv =====
// Small FIFO of decoded entries between front end and back end.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_i,
  input  wire u8u16_pkg::dec_entry_t  push_data_i,
  output logic                        full_o,
  input  wire logic                   pop_i,
  output logic                        valid_o,
  output u8u16_pkg::dec_entry_t       data_o
);

  localparam logic [u8u16_pkg::QPTR_W:0] FullCount = (u8u16_pkg::QPTR_W+1)'(u8u16_pkg::QDEPTH);

  u8u16_pkg::dec_entry_t            mem_q [u8u16_pkg::QDEPTH];
  logic [u8u16_pkg::QPTR_W-1:0]     wptr_q, rptr_q;
  logic [u8u16_pkg::QPTR_W:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCount);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !(pop_i && valid_o)) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i && valid_o) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i && valid_o) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue pop while empty");

endmodule

`default_nettype wire

// ===== design/u8u16_back.sv =====
// Back end: issues units against the limit and closes each string with a status item.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  input  wire u8u16_pkg::dec_entry_t entry_i,
  output logic                       pop_o,
  input  wire logic [15:0]           max_units_i,
  u8u16_unit_if.source               out_o
);

  logic [1:0]              slot_q, slot_d;
  logic [15:0]             cnt_q, cnt_d;
  logic                    stop_q, stop_d;
  logic                    ov_q, ov_d;
  logic [15:0]             cu_q, cu_d;
  logic                    uv_q, uv_d;
  logic                    fi_q, fi_d;
  u8u16_pkg::status_e      st_q, st_d;
  logic [15:0]             si_q, si_d;
  logic [15:0]             uw_q, uw_d;

  logic                    issue;
  logic [2:0]              n_slots;
  logic                    unit_slot;
  logic                    last_slot;
  logic [15:0]             cur_unit;

  assign issue     = valid_i && (!ov_q || out_o.ready);
  assign n_slots   = {1'b0, entry_i.n_units} + {2'b00, entry_i.last_byte};
  assign unit_slot = slot_q < entry_i.n_units;
  assign last_slot = (n_slots == 3'd0) || ({1'b0, slot_q} == n_slots - 3'd1);
  assign pop_o     = issue && last_slot;

  always_comb begin
    case (slot_q)
      2'd0:    cur_unit = entry_i.units[0];
      2'd1:    cur_unit = entry_i.units[1];
      2'd2:    cur_unit = entry_i.units[2];
      default: cur_unit = u8u16_pkg::QMARK;
    endcase
  end

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    stop_d = stop_q;
    ov_d   = ov_q && !out_o.ready;
    cu_d   = cu_q;
    uv_d   = uv_q;
    fi_d   = fi_q;
    st_d   = st_q;
    si_d   = si_q;
    uw_d   = uw_q;
    if (issue) begin
      slot_d = last_slot ? 2'd0 : slot_q + 2'd1;
      if (unit_slot) begin
        if (!stop_q) begin
          if (cnt_q < max_units_i) begin
            cnt_d = cnt_q + 16'd1;
            ov_d  = 1'b1;
            cu_d  = cur_unit;
            uv_d  = 1'b1;
            fi_d  = 1'b0;
            st_d  = u8u16_pkg::ST_DONE;
            si_d  = 16'd0;
            uw_d  = cnt_q + 16'd1;
          end else begin
            stop_d = 1'b1;
          end
        end
      end else if (entry_i.last_byte) begin
        // closing status; out of space takes precedence over a later short tail
        ov_d   = 1'b1;
        cu_d   = 16'd0;
        uv_d   = 1'b0;
        fi_d   = 1'b1;
        uw_d   = cnt_q;
        si_d   = 16'd0;
        if (stop_q) begin
          st_d = u8u16_pkg::ST_NO_SPACE;
        end else if (entry_i.incomplete) begin
          st_d = u8u16_pkg::ST_INCOMPLETE;
          si_d = entry_i.stop_idx;
        end else begin
          st_d = u8u16_pkg::ST_DONE;
        end
        cnt_d  = 16'd0;
        stop_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cu_q <= cu_d;
    uv_q <= uv_d;
    fi_q <= fi_d;
    st_q <= st_d;
    si_q <= si_d;
    uw_q <= uw_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 2'd0;
      cnt_q  <= 16'd0;
      stop_q <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      slot_q <= slot_d;
      cnt_q  <= cnt_d;
      stop_q <= stop_d;
      ov_q   <= ov_d;
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.code_unit     = cu_q;
  assign out_o.unit_valid    = uv_q;
  assign out_o.final_item    = fi_q;
  assign out_o.status        = st_q;
  assign out_o.stop_index    = si_q;
  assign out_o.units_written = uw_q;

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (uv_q ^ fi_q))
    else $error("result is neither a unit nor a status item");

  a_clear_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && !unit_slot && entry_i.last_byte) |=>
      (cnt_q == 16'd0) && !stop_q && (slot_q == 2'd0))
    else $error("string state not cleared after status item");

  a_stop_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(stop_q) |-> $past(issue && !unit_slot && entry_i.last_byte))
    else $error("out-of-space stop released before end of string");

endmodule

`default_nettype wire

// ===== design/utf8_to_utf16_decoder_unit.sv =====
// Top level: UTF-8 byte stream to UTF-16 code units with per-string status.
//
// Input channel in_i carries one UTF-8 byte per transfer; end_of_string marks
// the last byte of a string. Output channel out_o carries result items: one per
// produced code unit (unit_valid = 1), then one status item (final_item = 1)
// per string with status, stop_index and units_written.
// cfg_we_i / cfg_wdata_i write max_units; write only while the block is idle.
// The first result of a byte passes through the queue, then the output register.
// Throughput: one byte per cycle while each byte yields at most one result and
// the receiver accepts every result. The back end issues the candidate units and
// the status item of an entry in turn and then pops it, so an entry with several
// holds up the entries behind it; a four-entry queue between front end and back
// end absorbs these bursts, and in_i.ready drops only when that queue is full.
// A stalled receiver holds the output register; the queue keeps filling until
// full, then input stalls. Nothing is lost or repeated.
// Reset: max_units returns to 65535, all string state clears, no results pend.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_decoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  u8u16_byte_if.sink       in_i,
  u8u16_unit_if.source     out_o
);

  logic [15:0]           max_units_q;
  logic                  push;
  logic                  full;
  logic                  pop;
  logic                  q_valid;
  u8u16_pkg::dec_entry_t push_entry;
  u8u16_pkg::dec_entry_t head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_units_q <= u8u16_pkg::MAX_RESET;
    end else if (cfg_we_i) begin
      max_units_q <= cfg_wdata_i;
    end
  end

  u8u16_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  u8u16_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (head_entry)
  );

  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .entry_i     (head_entry),
    .pop_o       (pop),
    .max_units_i (max_units_q),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
